// File: rtl/core/double_hash_table_macros.svh
// ----------------------------------------------------------------------------
// double hash table assertion macros
// concurrent property wrappers used by the checker file
// ----------------------------------------------------------------------------
`ifndef DOUBLE_HASH_TABLE_MACROS_SVH
`define DOUBLE_HASH_TABLE_MACROS_SVH

// same-cycle implication
`define DHT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("double_hash_table assertion failed");

// next-cycle implication
`define DHT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("double_hash_table assertion failed");

`endif

// File: rtl/core/dht_pkg.sv
// ----------------------------------------------------------------------------
// dht_pkg
// constants, types and the digit-serial remainder step of the hash table
// ----------------------------------------------------------------------------
package dht_pkg;

  localparam int unsigned SLOTS        = 37;
  localparam int unsigned STEP_MODULUS = 13;
  localparam int unsigned KEY_BITS     = 31;

  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CMPS_W   = 6;
  localparam int unsigned IDX_W    = 6;

  localparam int unsigned DIG_W   = 4;
  localparam int unsigned NDIG    = (KEY_BITS + DIG_W - 1) / DIG_W;
  localparam int unsigned SV_W    = $clog2(STEP_MODULUS + 1);
  localparam int unsigned NDIG_S  = (SV_W + DIG_W - 1) / DIG_W;
  localparam int unsigned SH_DIG  = (NDIG > NDIG_S) ? NDIG : NDIG_S;
  localparam int unsigned SH_W    = SH_DIG * DIG_W;
  localparam int unsigned KEY_ALN = SH_W - NDIG * DIG_W;
  localparam int unsigned STP_ALN = SH_W - NDIG_S * DIG_W;
  localparam int unsigned MAX_M   = (SLOTS > STEP_MODULUS) ? SLOTS : STEP_MODULUS;
  localparam int unsigned REM_W   = $clog2(MAX_M + 1);
  localparam int unsigned POS_W   = $clog2(SLOTS);
  localparam int unsigned CMP_W   = $clog2(SLOTS + 1);
  localparam int unsigned CNT_MAX = (SLOTS > SH_DIG) ? SLOTS : SH_DIG;
  localparam int unsigned CNT_W   = $clog2(CNT_MAX);

  typedef logic [REM_W-1:0]    rem_t;
  typedef logic [POS_W-1:0]    pos_t;
  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [CMP_W-1:0]    cmp_t;

  localparam rem_t SLOTS_R = REM_W'(SLOTS);
  localparam rem_t STEP_R  = REM_W'(STEP_MODULUS);

  typedef enum logic [1:0] {
    MARK_EMPTY   = 2'd0,
    MARK_USED    = 2'd1,
    MARK_DELETED = 2'd2
  } mark_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DELETED   = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HASH,
    S_SETUP,
    S_STEP,
    S_PRIME,
    S_PROBE,
    S_FINISH
  } ctrl_state_e;

  typedef struct packed {
    key_t  key;
    mark_e mark;
  } entry_t;

  typedef struct packed {
    logic load;
    logic hash;
    logic setup;
    logic step;
    logic prime;
    logic probe;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic probe_done;
  } dp_stat_t;

  // (r * 2^DIG_W + d) mod m, for r < m
  function automatic rem_t mod_digit(rem_t r, logic [DIG_W-1:0] d, rem_t m);
    logic [REM_W+DIG_W-1:0] acc;
    logic [REM_W+DIG_W-1:0] sub;
    acc = {r, d};
    for (int j = DIG_W - 1; j >= 0; j--) begin
      sub = {{DIG_W{1'b0}}, m} << j;
      if (acc >= sub) begin
        acc = acc - sub;
      end
    end
    return acc[REM_W-1:0];
  endfunction

endpackage

// File: rtl/core/dht_req_if.sv
// ----------------------------------------------------------------------------
// dht_req_if
// request channel: action and key with valid/ready
// ----------------------------------------------------------------------------
interface dht_req_if;

  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [dht_pkg::KEY_BITS-1:0] key;

  modport source (output valid, output action, output key, input ready);
  modport sink   (input valid, input action, input key, output ready);

endinterface

// File: rtl/core/dht_rsp_if.sv
// ----------------------------------------------------------------------------
// dht_rsp_if
// response channel: status, comparison count and slot index with valid/ready
// ----------------------------------------------------------------------------
interface dht_rsp_if;

  logic                         valid;
  logic                         ready;
  logic [dht_pkg::STATUS_W-1:0] status;
  logic [dht_pkg::CMPS_W-1:0]   comparisons;
  logic [dht_pkg::IDX_W-1:0]    slot_index;

  modport source (output valid, output status, output comparisons, output slot_index,
                  input ready);
  modport sink   (input valid, input status, input comparisons, input slot_index,
                  output ready);

endinterface

// File: rtl/core/dht_ctrl.sv
// ----------------------------------------------------------------------------
// dht_ctrl
// sequencer for hashing, probing and write-back of one transaction
// ----------------------------------------------------------------------------
module dht_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  output logic               rsp_valid_o,
  input  logic               rsp_ready_i,
  input  dht_pkg::dp_stat_t  stat_i,
  output dht_pkg::dp_cmd_t   cmd_o
);

  dht_pkg::ctrl_state_e state_q, state_d;
  dht_pkg::cnt_t        cnt_q, cnt_d;
  logic                 out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dht_pkg::S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !rsp_ready_i;
    req_ready_o = (state_q == dht_pkg::S_IDLE);
    unique case (state_q)
      dht_pkg::S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = dht_pkg::S_HASH;
        end
      end
      dht_pkg::S_HASH: begin
        cmd_o.hash = 1'b1;
        if (cnt_q == dht_pkg::CNT_W'(dht_pkg::NDIG - 1)) begin
          cnt_d   = '0;
          state_d = dht_pkg::S_SETUP;
        end else begin
          cnt_d = cnt_q + dht_pkg::CNT_W'(1);
        end
      end
      dht_pkg::S_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = dht_pkg::S_STEP;
      end
      dht_pkg::S_STEP: begin
        cmd_o.step = 1'b1;
        if (cnt_q == dht_pkg::CNT_W'(dht_pkg::NDIG_S - 1)) begin
          cnt_d   = '0;
          state_d = dht_pkg::S_PRIME;
        end else begin
          cnt_d = cnt_q + dht_pkg::CNT_W'(1);
        end
      end
      dht_pkg::S_PRIME: begin
        cmd_o.prime = 1'b1;
        cnt_d       = '0;
        state_d     = dht_pkg::S_PROBE;
      end
      dht_pkg::S_PROBE: begin
        cmd_o.probe = 1'b1;
        if (stat_i.probe_done || cnt_q == dht_pkg::CNT_W'(dht_pkg::SLOTS - 1)) begin
          state_d = dht_pkg::S_FINISH;
        end else begin
          cnt_d = cnt_q + dht_pkg::CNT_W'(1);
        end
      end
      dht_pkg::S_FINISH: begin
        if (!out_valid_q || rsp_ready_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = dht_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = dht_pkg::S_IDLE;
      end
    endcase
  end

  assign rsp_valid_o = out_valid_q;

endmodule

// File: rtl/core/dht_datapath.sv
// ----------------------------------------------------------------------------
// dht_datapath
// remainder units, probe address walk, slot memory and result registers
// ----------------------------------------------------------------------------
module dht_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  dht_pkg::dp_cmd_t             cmd_i,
  output dht_pkg::dp_stat_t            stat_o,
  input  logic                         req_action_i,
  input  logic [dht_pkg::KEY_BITS-1:0] req_key_i,
  output logic [dht_pkg::STATUS_W-1:0] rsp_status_o,
  output logic [dht_pkg::CMPS_W-1:0]   rsp_comparisons_o,
  output logic [dht_pkg::IDX_W-1:0]    rsp_slot_index_o
);

  dht_pkg::entry_t mem [dht_pkg::SLOTS];
  logic [dht_pkg::SLOTS-1:0] valid_q;

  logic                          del_q;
  dht_pkg::key_t                 key_q;
  logic [dht_pkg::SH_W-1:0]      shift_q;
  dht_pkg::rem_t                 rem_h_q;
  dht_pkg::rem_t                 rem_s_q;
  dht_pkg::pos_t                 pos_q;
  dht_pkg::pos_t                 probe_pos_q;
  dht_pkg::entry_t               rd_q;
  logic                          rvalid_q;
  logic                          have_free_q;
  dht_pkg::pos_t                 free_pos_q;
  logic                          match_q;
  dht_pkg::pos_t                 hit_pos_q;
  dht_pkg::cmp_t                 cmp_q;
  dht_pkg::status_e              status_q;
  dht_pkg::cmp_t                 out_cmp_q;
  dht_pkg::pos_t                 out_idx_q;

  logic [dht_pkg::DIG_W-1:0] digit;
  logic [dht_pkg::SV_W-1:0]  step_val;
  logic [dht_pkg::POS_W:0]   pos_sum;
  dht_pkg::pos_t             pos_nxt;
  logic                      rd_en;
  dht_pkg::mark_e            mark;
  logic                      is_empty;
  logic                      is_used;
  logic                      hit;
  logic                      wr_en;
  dht_pkg::pos_t             wr_addr;
  dht_pkg::entry_t           wr_data;
  dht_pkg::status_e          fin_status;
  dht_pkg::pos_t             fin_idx;

  assign digit    = shift_q[dht_pkg::SH_W-1 -: dht_pkg::DIG_W];
  assign step_val = dht_pkg::SV_W'(rem_s_q) + dht_pkg::SV_W'(1);
  assign pos_sum  = {1'b0, pos_q} + {1'b0, dht_pkg::POS_W'(rem_h_q)};
  assign pos_nxt  = (pos_sum >= (dht_pkg::POS_W + 1)'(dht_pkg::SLOTS))
                  ? dht_pkg::POS_W'(pos_sum - (dht_pkg::POS_W + 1)'(dht_pkg::SLOTS))
                  : dht_pkg::POS_W'(pos_sum);
  assign rd_en    = cmd_i.prime || cmd_i.probe;

  // probe evaluation
  assign mark     = rvalid_q ? rd_q.mark : dht_pkg::MARK_EMPTY;
  assign is_empty = (mark == dht_pkg::MARK_EMPTY);
  assign is_used  = (mark == dht_pkg::MARK_USED);
  assign hit      = is_used && (rd_q.key == key_q);
  assign stat_o.probe_done = is_empty || hit;

  // outcome and write-back
  always_comb begin
    wr_en      = 1'b0;
    wr_addr    = hit_pos_q;
    fin_idx    = '0;
    fin_status = dht_pkg::ST_FULL;
    wr_data.key  = key_q;
    wr_data.mark = del_q ? dht_pkg::MARK_DELETED : dht_pkg::MARK_USED;
    priority if (match_q && del_q) begin
      fin_status = dht_pkg::ST_DELETED;
      fin_idx    = hit_pos_q;
      wr_en      = cmd_i.finish;
    end else if (match_q) begin
      fin_status = dht_pkg::ST_DUPLICATE;
    end else if (del_q) begin
      fin_status = dht_pkg::ST_NOT_FOUND;
    end else if (have_free_q) begin
      fin_status = dht_pkg::ST_INSERTED;
      fin_idx    = free_pos_q;
      wr_addr    = free_pos_q;
      wr_en      = cmd_i.finish;
    end else begin
      fin_status = dht_pkg::ST_FULL;
    end
  end

  // slot memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[pos_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_q[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rvalid_q <= valid_q[pos_q];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      del_q   <= req_action_i;
      key_q   <= req_key_i;
      shift_q <= dht_pkg::SH_W'(req_key_i) << dht_pkg::KEY_ALN;
      rem_h_q <= '0;
      rem_s_q <= '0;
    end
    if (cmd_i.hash) begin
      rem_h_q <= dht_pkg::mod_digit(rem_h_q, digit, dht_pkg::SLOTS_R);
      rem_s_q <= dht_pkg::mod_digit(rem_s_q, digit, dht_pkg::STEP_R);
      shift_q <= shift_q << dht_pkg::DIG_W;
    end
    if (cmd_i.setup) begin
      pos_q   <= dht_pkg::POS_W'(rem_h_q);
      rem_h_q <= '0;
      shift_q <= dht_pkg::SH_W'(step_val) << dht_pkg::STP_ALN;
    end
    if (cmd_i.step) begin
      rem_h_q <= dht_pkg::mod_digit(rem_h_q, digit, dht_pkg::SLOTS_R);
      shift_q <= shift_q << dht_pkg::DIG_W;
    end
    if (rd_en) begin
      probe_pos_q <= pos_q;
      pos_q       <= pos_nxt;
    end
    if (cmd_i.prime) begin
      have_free_q <= 1'b0;
      free_pos_q  <= '0;
      match_q     <= 1'b0;
      hit_pos_q   <= '0;
      cmp_q       <= '0;
    end
    if (cmd_i.probe) begin
      if (!is_used && !have_free_q) begin
        have_free_q <= 1'b1;
        free_pos_q  <= probe_pos_q;
      end
      if (is_used) begin
        cmp_q <= cmp_q + dht_pkg::CMP_W'(1);
      end
      if (hit) begin
        match_q   <= 1'b1;
        hit_pos_q <= probe_pos_q;
      end
    end
    if (cmd_i.finish) begin
      status_q  <= fin_status;
      out_cmp_q <= cmp_q;
      out_idx_q <= fin_idx;
    end
  end

  assign rsp_status_o      = status_q;
  assign rsp_comparisons_o = dht_pkg::CMPS_W'(out_cmp_q);
  assign rsp_slot_index_o  = dht_pkg::IDX_W'(out_idx_q);

endmodule

// File: rtl/core/double_hash_table.sv
// sequence: a request passes the hash, setup, step, prime, probe and finish states in order;
// one item in flight at a time, and finish waits while an earlier response is still held
// a request takes 1 to 37 probes; the 4-bit-per-cycle remainder unit and the slot memory
// walked at one probe per cycle set the time spent hashing and probing
// reset: asynchronous, active low; all slots read as empty at once, no clearing pass
// ----------------------------------------------------------------------------
// double_hash_table
// open-addressing hash table with double hashing, insert and delete requests
// ----------------------------------------------------------------------------
module double_hash_table (
  input  logic      clk_i,
  input  logic      rst_ni,
  dht_req_if.sink   req_i,
  dht_rsp_if.source rsp_o
);

  dht_pkg::dp_cmd_t  cmd;
  dht_pkg::dp_stat_t stat;

  dht_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  dht_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .req_action_i      (req_i.action),
    .req_key_i         (req_i.key),
    .rsp_status_o      (rsp_o.status),
    .rsp_comparisons_o (rsp_o.comparisons),
    .rsp_slot_index_o  (rsp_o.slot_index)
  );

endmodule

// File: rtl/core/dht_checker.sv
// ----------------------------------------------------------------------------
// dht_checker
// port-level properties of the hash table, bound to the top level
// ----------------------------------------------------------------------------
`include "double_hash_table_macros.svh"

module dht_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         req_valid_i,
  input logic                         req_ready_i,
  input logic                         rsp_valid_i,
  input logic                         rsp_ready_i,
  input logic [dht_pkg::STATUS_W-1:0] rsp_status_i,
  input logic [dht_pkg::CMPS_W-1:0]   rsp_comparisons_i,
  input logic [dht_pkg::IDX_W-1:0]    rsp_slot_index_i
);

  logic [dht_pkg::STATUS_W+dht_pkg::CMPS_W+dht_pkg::IDX_W-1:0] rsp_payload;
  logic req_fire;
  logic rsp_stall;
  logic rsp_no_change;
  logic rsp_full;
  logic rsp_in_range;

  assign rsp_payload   = {rsp_status_i, rsp_comparisons_i, rsp_slot_index_i};
  assign req_fire      = req_valid_i && req_ready_i;
  assign rsp_stall     = rsp_valid_i && !rsp_ready_i;
  assign rsp_no_change = rsp_valid_i && (rsp_status_i == dht_pkg::ST_DUPLICATE ||
                                         rsp_status_i == dht_pkg::ST_NOT_FOUND ||
                                         rsp_status_i == dht_pkg::ST_FULL);
  assign rsp_full      = rsp_valid_i && rsp_status_i == dht_pkg::ST_FULL;
  assign rsp_in_range  = rsp_comparisons_i <= dht_pkg::CMPS_W'(dht_pkg::SLOTS) &&
                         rsp_slot_index_i < dht_pkg::IDX_W'(dht_pkg::SLOTS);

  `DHT_ASSERT_NEXT(a_busy_after_req, clk_i, rst_ni, req_fire, !req_ready_i)
  `DHT_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_stall, rsp_valid_i && $stable(rsp_payload))
  `DHT_ASSERT_IMPL(a_idx_zero, clk_i, rst_ni, rsp_no_change, rsp_slot_index_i == '0)
  `DHT_ASSERT_IMPL(a_full_cmp, clk_i, rst_ni, rsp_full, rsp_comparisons_i == 6'(dht_pkg::SLOTS))
  `DHT_ASSERT_IMPL(a_rsp_range, clk_i, rst_ni, rsp_valid_i, rsp_in_range)

endmodule

bind double_hash_table dht_checker u_dht_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .req_valid_i       (req_i.valid),
  .req_ready_i       (req_i.ready),
  .rsp_valid_i       (rsp_o.valid),
  .rsp_ready_i       (rsp_o.ready),
  .rsp_status_i      (rsp_o.status),
  .rsp_comparisons_i (rsp_o.comparisons),
  .rsp_slot_index_i  (rsp_o.slot_index)
);
